>>> src/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, codes and constants of the multiplexed seven-segment driver.
// ----------------------------------------------------------------------------
package msd_pkg;

	localparam int DIGIT_SLOTS_DEF = 8;
	localparam int IDX_W           = 3;
	localparam int CNT_W           = 4;
	localparam int SEG_W           = 8;
	localparam int EN_W            = 8;
	localparam int MODE_W          = 3;
	localparam int BLINK_W         = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;

	localparam logic [SEG_W-1:0]   BLANK_GLYPH  = 8'h00;
	localparam logic [SEG_W-1:0]   POINT_BIT    = 8'h80;
	localparam logic [SEG_W-1:0]   CHAR_SPACE   = 8'h20;
	localparam logic [SEG_W-1:0]   CHAR_ZERO    = 8'h30;
	localparam logic [SEG_W-1:0]   CHAR_NINE    = 8'h39;
	localparam logic [BLINK_W-1:0] BLINK_TICKS_RST = 16'd100;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK  = 3'd0,
		MODE_CHAR  = 3'd1,
		MODE_RAW   = 3'd2,
		MODE_DOTS  = 3'd3,
		MODE_CLEAR = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		BLINK_OFF = 2'd0,
		BLINK_ALL = 2'd1,
		BLINK_ONE = 2'd2
	} blink_sel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIGIT_COUNT  = 3'd0,
		REG_BLINK_SELECT = 3'd1,
		REG_BLINK_TICKS  = 3'd2,
		REG_BLINK_TARGET = 3'd3,
		REG_ACTIVE_LOW   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_DOTS,
		ST_CLEAR
	} state_t;

	// request payload
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  digit_index;
		logic [SEG_W-1:0]  value;
		logic [CNT_W-1:0]  dot_count;
	} req_t;

	// result payload
	typedef struct packed {
		logic [SEG_W-1:0] segments;
		logic [EN_W-1:0]  digit_enable;
		logic             drive_valid;
		logic             error;
	} rsp_t;

	// live configuration and restart strobes
	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [1:0]         blink_select;
		logic [BLINK_W-1:0] blink_ticks;
		logic [IDX_W-1:0]   blink_target;
		logic               active_low;
		logic               blink_restart;
		logic               phase_clear;
	} cfg_t;

	// segment store access, one read and one write per cycle
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [SEG_W-1:0] wr_data;
	} mem_req_t;

	// ascii digit to segment pattern
	function automatic logic [SEG_W-1:0] char_glyph(input logic [SEG_W-1:0] ch);
		logic [SEG_W-1:0] g;
		unique case (ch)
			8'h30:   g = 8'h3f;
			8'h31:   g = 8'h06;
			8'h32:   g = 8'h5b;
			8'h33:   g = 8'h4f;
			8'h34:   g = 8'h66;
			8'h35:   g = 8'h6d;
			8'h36:   g = 8'h7d;
			8'h37:   g = 8'h07;
			8'h38:   g = 8'h7f;
			8'h39:   g = 8'h6f;
			default: g = BLANK_GLYPH;
		endcase
		return g;
	endfunction

endpackage

>>> src/msd_stream_if.sv
// ----------------------------------------------------------------------------
// msd_stream_if
// Valid/ready channel carrying one payload word per request.
// ----------------------------------------------------------------------------
interface msd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/msd_cfg.sv
// ----------------------------------------------------------------------------
// msd_cfg
// Configuration registers with live digit count and blink restart strobes.
// ----------------------------------------------------------------------------
module msd_cfg #(
	parameter int DIGIT_SLOTS = msd_pkg::DIGIT_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [msd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [msd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output msd_pkg::cfg_t                    cfg
);
	import msd_pkg::*;

	logic [CNT_W-1:0]   digit_count_q;
	logic [1:0]         blink_select_q;
	logic [BLINK_W-1:0] blink_ticks_q;
	logic [IDX_W-1:0]   blink_target_q;
	logic               active_low_q;
	logic [CNT_W-1:0]   live_count;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q  <= CNT_W'(DIGIT_SLOTS_DEF);
			blink_select_q <= BLINK_OFF;
			blink_ticks_q  <= BLINK_TICKS_RST;
			blink_target_q <= '0;
			active_low_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIGIT_COUNT:  digit_count_q  <= cfg_data[CNT_W-1:0];
				REG_BLINK_SELECT: blink_select_q <= cfg_data[1:0];
				REG_BLINK_TICKS:  blink_ticks_q  <= cfg_data[BLINK_W-1:0];
				REG_BLINK_TARGET: blink_target_q <= cfg_data[IDX_W-1:0];
				REG_ACTIVE_LOW:   active_low_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// zero acts as one, too large acts as the slot count
	always_comb begin
		if (digit_count_q == '0) begin
			live_count = CNT_W'(1);
		end else if (digit_count_q > CNT_W'(DIGIT_SLOTS)) begin
			live_count = CNT_W'(DIGIT_SLOTS);
		end else begin
			live_count = digit_count_q;
		end
	end

	assign cfg.count         = live_count;
	assign cfg.blink_select  = blink_select_q;
	assign cfg.blink_ticks   = blink_ticks_q;
	assign cfg.blink_target  = blink_target_q;
	assign cfg.active_low    = active_low_q;
	assign cfg.blink_restart = cfg_we && (cfg_index == REG_BLINK_SELECT ||
		cfg_index == REG_BLINK_TICKS);
	assign cfg.phase_clear   = cfg_we && (cfg_index == REG_BLINK_SELECT);

endmodule

>>> src/msd_store.sv
// ----------------------------------------------------------------------------
// msd_store
// Segment store: synchronous memory, one read and one write port, registered
// read data; per-entry valid bits make unwritten entries read as blank.
// ----------------------------------------------------------------------------
module msd_store #(
	parameter int DIGIT_SLOTS = msd_pkg::DIGIT_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  msd_pkg::mem_req_t             mem,
	output logic [msd_pkg::SEG_W-1:0]     rd_data
);
	import msd_pkg::*;

	localparam int AW = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;

	logic [SEG_W-1:0]       mem_q [DIGIT_SLOTS];
	logic [DIGIT_SLOTS-1:0] valid_q;
	logic [SEG_W-1:0]       rd_q;
	logic                   rd_valid_q;

	// memory array
	always_ff @(posedge clk) begin
		if (mem.wr_en) begin
			mem_q[mem.wr_addr[AW-1:0]] <= mem.wr_data;
		end
		if (mem.rd_en) begin
			rd_q <= mem_q[mem.rd_addr[AW-1:0]];
		end
	end

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (mem.wr_en) begin
				valid_q[mem.wr_addr[AW-1:0]] <= 1'b1;
			end
			if (mem.rd_en) begin
				rd_valid_q <= valid_q[mem.rd_addr[AW-1:0]];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : BLANK_GLYPH;

endmodule

>>> src/msd_ctrl.sv
// ----------------------------------------------------------------------------
// msd_ctrl
// Request sequencer: checks requests, drives the store, runs the scan and
// blink state and holds the result register.
// ----------------------------------------------------------------------------
module msd_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  msd_pkg::cfg_t             cfg,
	msd_stream_if.sink                req,
	msd_stream_if.source              rsp,
	output msd_pkg::mem_req_t         mem,
	input  logic [msd_pkg::SEG_W-1:0] mem_rd_data
);
	import msd_pkg::*;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   scan_q;
	logic [BLINK_W-1:0] blink_cnt_q;
	logic               phase_q;
	logic               out_v_q;
	rsp_t               out_q;
	logic [IDX_W-1:0]   pos_s1;
	logic               blank_s1;
	logic [IDX_W-1:0]   rmw_addr_s1;
	logic [IDX_W-1:0]   next_addr_q;
	logic [CNT_W-1:0]   remain_q;
	logic [IDX_W-1:0]   clr_addr_q;

	logic               req_fire;
	logic               out_load;
	rsp_t               out_d;
	logic               tick_go, dots_go, clr_go;
	logic [IDX_W-1:0]   tick_pos, scan_adv;
	logic [CNT_W-1:0]   pos_inc;
	logic               blink_on, blank, wrap;
	logic [BLINK_W-1:0] cnt_inc;
	logic               idx_ok, char_ok, dots_ok;
	logic [CNT_W:0]     span_end;
	logic [SEG_W-1:0]   tick_seg;
	logic [EN_W-1:0]    tick_en;
	logic [CNT_W-1:0]   clr_next;

	assign req.ready = (state_q == ST_IDLE) && (!out_v_q || rsp.ready);
	assign req_fire  = req.valid && req.ready;

	// scan position and blanking for a tick
	always_comb begin
		tick_pos = ({1'b0, scan_q} >= cfg.count) ? '0 : scan_q;
		pos_inc  = {1'b0, tick_pos} + CNT_W'(1);
		scan_adv = (pos_inc >= cfg.count) ? '0 : pos_inc[IDX_W-1:0];
		blink_on = (cfg.blink_select == BLINK_ALL) || (cfg.blink_select == BLINK_ONE);
		if (cfg.blink_select == BLINK_ALL) begin
			blank = phase_q;
		end else if (cfg.blink_select == BLINK_ONE) begin
			blank = phase_q && (tick_pos == cfg.blink_target);
		end else begin
			blank = 1'b0;
		end
		cnt_inc = blink_cnt_q + BLINK_W'(1);
		wrap    = (cnt_inc >= cfg.blink_ticks);
	end

	// request checks
	always_comb begin
		idx_ok   = ({1'b0, req.data.digit_index} < cfg.count);
		char_ok  = (req.data.value == CHAR_SPACE) ||
			(req.data.value >= CHAR_ZERO && req.data.value <= CHAR_NINE);
		span_end = {2'b00, req.data.digit_index} + {1'b0, req.data.dot_count};
		dots_ok  = idx_ok && (span_end <= {1'b0, cfg.count});
	end

	// tick result from the store read
	always_comb begin
		tick_seg = blank_s1 ? BLANK_GLYPH : mem_rd_data;
		tick_en  = EN_W'(1) << pos_s1;
		if (cfg.active_low) begin
			tick_seg = ~tick_seg;
			tick_en  = ~tick_en;
		end
		clr_next = {1'b0, clr_addr_q} + CNT_W'(1);
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		mem      = '0;
		out_load = 1'b0;
		out_d    = '0;
		tick_go  = 1'b0;
		dots_go  = 1'b0;
		clr_go   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					unique case (req.data.mode)
						MODE_TICK: begin
							tick_go     = 1'b1;
							mem.rd_en   = 1'b1;
							mem.rd_addr = tick_pos;
							state_d     = ST_TICK;
						end
						MODE_CHAR: begin
							out_load    = 1'b1;
							out_d.error = !(idx_ok && char_ok);
							mem.wr_en   = idx_ok && char_ok;
							mem.wr_addr = req.data.digit_index;
							mem.wr_data = char_glyph(req.data.value);
						end
						MODE_RAW: begin
							out_load    = 1'b1;
							out_d.error = !idx_ok;
							mem.wr_en   = idx_ok;
							mem.wr_addr = req.data.digit_index;
							mem.wr_data = req.data.value;
						end
						MODE_DOTS: begin
							out_load    = 1'b1;
							out_d.error = !dots_ok;
							if (dots_ok && req.data.dot_count != '0) begin
								dots_go     = 1'b1;
								mem.rd_en   = 1'b1;
								mem.rd_addr = req.data.digit_index;
								state_d     = ST_DOTS;
							end
						end
						MODE_CLEAR: begin
							out_load    = 1'b1;
							clr_go      = 1'b1;
							mem.wr_en   = 1'b1;
							mem.wr_addr = '0;
							mem.wr_data = BLANK_GLYPH;
							if (cfg.count > CNT_W'(1)) begin
								state_d = ST_CLEAR;
							end
						end
						default: begin
							out_load    = 1'b1;
							out_d.error = 1'b1;
						end
					endcase
				end
			end
			ST_TICK: begin
				out_load           = 1'b1;
				out_d.segments     = tick_seg;
				out_d.digit_enable = tick_en;
				out_d.drive_valid  = 1'b1;
				state_d            = ST_IDLE;
			end
			ST_DOTS: begin
				// write back the entry read last cycle, read the next one
				mem.wr_en   = 1'b1;
				mem.wr_addr = rmw_addr_s1;
				mem.wr_data = mem_rd_data | POINT_BIT;
				if (remain_q != '0) begin
					mem.rd_en   = 1'b1;
					mem.rd_addr = next_addr_q;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = clr_addr_q;
				mem.wr_data = BLANK_GLYPH;
				if (clr_next >= cfg.count) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan and blink state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			blink_cnt_q <= '0;
			phase_q     <= 1'b0;
		end else begin
			if (tick_go) begin
				scan_q <= scan_adv;
			end else if (clr_go) begin
				scan_q <= '0;
			end
			if (cfg.blink_restart) begin
				blink_cnt_q <= '0;
			end else if (tick_go && blink_on) begin
				blink_cnt_q <= wrap ? '0 : cnt_inc;
			end
			if (cfg.phase_clear) begin
				phase_q <= 1'b0;
			end else if (tick_go && blink_on && wrap) begin
				phase_q <= ~phase_q;
			end
		end
	end

	// sweep counters and tick stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_s1      <= '0;
			blank_s1    <= 1'b0;
			rmw_addr_s1 <= '0;
			next_addr_q <= '0;
			remain_q    <= '0;
			clr_addr_q  <= '0;
		end else begin
			if (tick_go) begin
				pos_s1   <= tick_pos;
				blank_s1 <= blank;
			end
			if (dots_go) begin
				rmw_addr_s1 <= req.data.digit_index;
				next_addr_q <= req.data.digit_index + IDX_W'(1);
				remain_q    <= req.data.dot_count - CNT_W'(1);
			end else if (state_q == ST_DOTS && remain_q != '0) begin
				rmw_addr_s1 <= next_addr_q;
				next_addr_q <= next_addr_q + IDX_W'(1);
				remain_q    <= remain_q - CNT_W'(1);
			end
			if (clr_go) begin
				clr_addr_q <= IDX_W'(1);
			end else if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

endmodule

>>> src/multiplexed_seven_segment_driver.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver
// Eight-entry segment store with character, raw and dot writes, clear, and
// refresh ticks that scan one digit each with optional blinking.
//
//   port   dir  handshake     payload
//   req    in   valid/ready   mode, digit_index, value, dot_count
//   rsp    out  valid/ready   segments, digit_enable, drive_valid, error
//   cfg    in   write enable  cfg_index, cfg_data
//
// Char, raw, clear with one digit and rejected requests: the result is registered as the request is taken.
// Tick: the segment store read is registered, then the result register is loaded from it.
// Set dots: one read-modify-write per digit.
// Clear: one store entry written per cycle.
// A new request is taken when the sequencer is idle and the result register is
// empty or being drained. Reset leaves the store reading as blank.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_driver #(
	parameter int DIGIT_SLOTS = msd_pkg::DIGIT_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [msd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msd_pkg::CFG_DATA_W-1:0] cfg_data,
	msd_stream_if.sink                     req,
	msd_stream_if.source                   rsp
);
	import msd_pkg::*;

	cfg_t             cfg;
	mem_req_t         mem;
	logic [SEG_W-1:0] mem_rd_data;

	msd_cfg #(
		.DIGIT_SLOTS(DIGIT_SLOTS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	msd_store #(
		.DIGIT_SLOTS(DIGIT_SLOTS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.mem    (mem),
		.rd_data(mem_rd_data)
	);

	msd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req        (req),
		.rsp        (rsp),
		.mem        (mem),
		.mem_rd_data(mem_rd_data)
	);

endmodule

>>> src/msd_checker.sv
// ----------------------------------------------------------------------------
// msd_checker
// Port-level checks of the seven-segment driver, bound to the top level.
// ----------------------------------------------------------------------------
module msd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input msd_pkg::req_t req_data,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input msd_pkg::rsp_t rsp_data
);
	import msd_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// non-drive results carry no pattern
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.drive_valid |->
			rsp_data.segments == '0 && rsp_data.digit_enable == '0)
		else $error("pattern on a non-drive result");

	// exactly one digit selected, in either polarity
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.drive_valid |->
			$onehot(rsp_data.digit_enable) || $onehot(~rsp_data.digit_enable))
		else $error("digit enable not one-hot");

	// a tick never reports an error
	a_drive_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.drive_valid |-> !rsp_data.error)
		else $error("error flagged on a tick");

	// a tick request waits for its store read
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.mode == MODE_TICK |=> !req_ready)
		else $error("request taken during tick read");

endmodule

bind multiplexed_seven_segment_driver msd_checker u_msd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_data (req.data),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);

>>> tb/multiplexed_seven_segment_driver_test.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver_test
// Drives character, raw, dot, clear and refresh-tick requests into the driver
// under a series of register settings (digit counts in and out of range, all
// blink modes, inverted outputs) and checks every result against a local
// model of the segment store, scan position and blink phase.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_driver_test;

	import msd_pkg::*;

	localparam int          DIGITS         = DIGIT_SLOTS_DEF;
	localparam int          SETTLE_CYCLES  = 24;
	localparam int          SETTINGS_RUN   = 15;
	localparam int          PHASE_REQUESTS = 107;
	localparam int          MISMATCH_SHOWN = 40;
	localparam logic [1:0]  BLINK_SPARE    = 2'd3;
	localparam logic [MODE_W-1:0] MODE_LAST_CODE = '1;
	localparam logic [SEG_W-1:0] DIGIT_GLYPHS [10] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	msd_stream_if #(.payload_t(req_t)) req_ch ();
	msd_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	multiplexed_seven_segment_driver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// display model state and register copy
	logic [SEG_W-1:0]   digit_store [DIGITS];
	int unsigned        scan_pos;
	logic [BLINK_W-1:0] blink_cnt;
	logic               blink_phase;
	logic [CNT_W-1:0]   digit_count;
	logic [1:0]         blink_sel;
	logic [BLINK_W-1:0] blink_ticks;
	logic [IDX_W-1:0]   blink_target;
	logic               invert_out;

	req_t pending_requests [$];
	rsp_t expected_outputs [$];
	int   queued_count;
	int   accepted_count;
	int   mismatches;
	int   ticks_driven;
	int   rejected;
	int   phase_flips;
	int   burst_left;
	int   gap_left;
	logic [15:0] stall_pattern;
	logic [4:0]  stall_step;

	// clock and known input levels from time zero
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DIGIT_COUNT;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned active_digits();
		if (digit_count == 0) return 1;
		if (digit_count > DIGITS) return DIGITS;
		return digit_count;
	endfunction

	// expected result of one request, updates the model state
	function automatic rsp_t predict_display(req_t r);
		rsp_t o;
		int unsigned n;
		int unsigned pos;
		int unsigned i;
		logic blank;
		o = '0;
		n = active_digits();
		case (r.mode)
			MODE_TICK: begin
				pos = (scan_pos >= n) ? 0 : scan_pos;
				blank = 1'b0;
				if (blink_sel == BLINK_ALL) blank = blink_phase;
				else if (blink_sel == BLINK_ONE) blank = blink_phase && (pos == blink_target);
				o.segments = blank ? BLANK_GLYPH : digit_store[pos];
				o.digit_enable = 8'h01 << pos;
				if (invert_out) begin
					o.segments = ~o.segments;
					o.digit_enable = ~o.digit_enable;
				end
				o.drive_valid = 1'b1;
				pos = pos + 1;
				scan_pos = (pos >= n) ? 0 : pos;
				if (blink_sel == BLINK_ALL || blink_sel == BLINK_ONE) begin
					blink_cnt = blink_cnt + 1'b1;
					if (blink_cnt >= blink_ticks) begin
						blink_cnt = '0;
						blink_phase = ~blink_phase;
						phase_flips++;
					end
				end
				ticks_driven++;
			end
			MODE_CHAR: begin
				if (r.digit_index >= n) o.error = 1'b1;
				else if (r.value == CHAR_SPACE) digit_store[r.digit_index] = BLANK_GLYPH;
				else if (r.value >= CHAR_ZERO && r.value <= CHAR_NINE)
					digit_store[r.digit_index] = DIGIT_GLYPHS[r.value - CHAR_ZERO];
				else o.error = 1'b1;
			end
			MODE_RAW: begin
				if (r.digit_index >= n) o.error = 1'b1;
				else digit_store[r.digit_index] = r.value;
			end
			MODE_DOTS: begin
				if (r.digit_index >= n || r.digit_index + r.dot_count > n) o.error = 1'b1;
				else
					for (i = r.digit_index; i < r.digit_index + r.dot_count; i++)
						digit_store[i] = digit_store[i] | POINT_BIT;
			end
			MODE_CLEAR: begin
				for (i = 0; i < n; i++) digit_store[i] = BLANK_GLYPH;
				scan_pos = 0;
			end
			default: o.error = 1'b1;
		endcase
		if (o.error) rejected++;
		return o;
	endfunction

	function automatic req_t make_request(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
			logic [SEG_W-1:0] value, logic [CNT_W-1:0] dots);
		req_t r;
		r.mode = mode;
		r.digit_index = idx;
		r.value = value;
		r.dot_count = dots;
		return r;
	endfunction

	// mostly well-formed requests for the live digit count, some noise
	function automatic req_t random_request(int unsigned n);
		req_t r;
		int unsigned pick;
		r = make_request(MODE_TICK, $urandom, $urandom, $urandom);
		pick = $urandom_range(99);
		if (pick < 40) begin
			r.mode = MODE_TICK;
		end else if (pick < 58) begin
			r.mode = MODE_CHAR;
			if ($urandom_range(9) < 8)
				r.value = ($urandom_range(10) == 10) ? CHAR_SPACE : CHAR_ZERO + $urandom_range(9);
			if ($urandom_range(9) < 8) r.digit_index = $urandom_range(n - 1);
		end else if (pick < 72) begin
			r.mode = MODE_RAW;
			if ($urandom_range(9) < 8) r.digit_index = $urandom_range(n - 1);
		end else if (pick < 84) begin
			r.mode = MODE_DOTS;
			if ($urandom_range(9) < 8) begin
				r.digit_index = $urandom_range(n - 1);
				r.dot_count = $urandom_range(n - r.digit_index);
			end
		end else if (pick < 89) begin
			r.mode = MODE_CLEAR;
		end else if (pick < 94) begin
			r.mode = $urandom_range(MODE_CLEAR + 1, MODE_LAST_CODE);
		end
		return r;
	endfunction

	task automatic queue_request(req_t r);
		pending_requests.push_back(r);
		queued_count++;
	endtask

	// wait until every request is answered, then let the sequencer settle
	task automatic drain();
		while (accepted_count != queued_count || expected_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write with random bits above the field
	task automatic set_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
		int w;
		logic [CFG_DATA_W-1:0] noise;
		logic [CFG_DATA_W-1:0] mask;
		noise = $urandom;
		case (which)
			REG_DIGIT_COUNT: begin
				w = CNT_W;
				digit_count = value[CNT_W-1:0];
			end
			REG_BLINK_SELECT: begin
				w = 2;
				blink_sel = value[1:0];
				blink_cnt = '0;
				blink_phase = 1'b0;
			end
			REG_BLINK_TICKS: begin
				w = BLINK_W;
				blink_ticks = value;
				blink_cnt = '0;
			end
			REG_BLINK_TARGET: begin
				w = IDX_W;
				blink_target = value[IDX_W-1:0];
			end
			default: begin
				w = 1;
				invert_out = value[0];
			end
		endcase
		mask = (16'd1 << w) - 16'd1;
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= (noise & ~mask) | (value & mask);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(logic [CNT_W-1:0] cnt, logic [1:0] sel, logic [BLINK_W-1:0] ticks,
			logic [IDX_W-1:0] target, logic inv);
		set_reg(REG_DIGIT_COUNT, cnt);
		set_reg(REG_BLINK_SELECT, sel);
		set_reg(REG_BLINK_TICKS, ticks);
		set_reg(REG_BLINK_TARGET, target);
		set_reg(REG_ACTIVE_LOW, inv);
	endtask

	// one register setting per phase, extremes first
	task automatic apply_setting(int k);
		logic [BLINK_W-1:0] ticks;
		case (k)
			0: set_all(1, BLINK_ALL, 0, 0, 1'b0);
			1: set_all(0, BLINK_ONE, 1, 0, 1'b1);
			2: set_all(15, BLINK_ONE, 3, 7, 1'b0);
			3: set_all(8, BLINK_ALL, 65535, 5, 1'b1);
			4: set_all(3, BLINK_ONE, 2, 6, 1'b1);
			5: set_all(9, BLINK_SPARE, 65535, 2, 1'b0);
			6: set_all(5, BLINK_ONE, 4, 4, 1'b0);
			default: begin
				case ($urandom_range(9))
					0, 1: ticks = 0;
					2: ticks = BLINK_TICKS_RST;
					3: ticks = $urandom;
					default: ticks = $urandom_range(1, 6);
				endcase
				if ($urandom_range(3) != 0)
					set_reg(REG_DIGIT_COUNT,
						($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(1, 8));
				if ($urandom_range(3) != 0) set_reg(REG_BLINK_SELECT, $urandom_range(3));
				if ($urandom_range(3) != 0) set_reg(REG_BLINK_TICKS, ticks);
				if ($urandom_range(3) != 0) set_reg(REG_BLINK_TARGET, $urandom_range(7));
				if ($urandom_range(3) != 0) set_reg(REG_ACTIVE_LOW, $urandom_range(1));
			end
		endcase
	endtask

	// request sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				req_ch.valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				req_ch.data <= pending_requests.pop_front();
				req_ch.valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver: stall pattern renewed each time the step counter wraps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_pattern <= '1;
			stall_step <= '0;
		end else begin
			stall_step <= stall_step + 1'b1;
			rsp_ch.ready <= stall_pattern[stall_step[3:0]];
			if (stall_step == '1) begin
				case ($urandom_range(4))
					0, 1: stall_pattern <= '1;
					2: stall_pattern <= $urandom | $urandom;
					default: stall_pattern <= $urandom;
				endcase
			end
		end
	end

	task automatic report_field(string field, logic [SEG_W-1:0] want, logic [SEG_W-1:0] got);
		mismatches++;
		if (mismatches <= MISMATCH_SHOWN)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endtask

	// predict on accepted requests, check accepted results in order
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				expected_outputs.push_back(predict_display(req_ch.data));
				accepted_count++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_outputs.size() == 0) begin
					report_field("unexpected result", '0, rsp_ch.data.segments);
				end else begin
					want = expected_outputs.pop_front();
					if (want.segments !== rsp_ch.data.segments)
						report_field("segments", want.segments, rsp_ch.data.segments);
					if (want.digit_enable !== rsp_ch.data.digit_enable)
						report_field("digit_enable", want.digit_enable, rsp_ch.data.digit_enable);
					if (want.drive_valid !== rsp_ch.data.drive_valid)
						report_field("drive_valid", want.drive_valid, rsp_ch.data.drive_valid);
					if (want.error !== rsp_ch.data.error)
						report_field("error", want.error, rsp_ch.data.error);
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		int k;
		int m;
		int n;
		for (k = 0; k < DIGITS; k++) digit_store[k] = BLANK_GLYPH;
		scan_pos = 0;
		blink_cnt = '0;
		blink_phase = 1'b0;
		digit_count = DIGITS;
		blink_sel = BLINK_OFF;
		blink_ticks = BLINK_TICKS_RST;
		blink_target = '0;
		invert_out = 1'b0;
		queued_count = 0;
		accepted_count = 0;
		mismatches = 0;
		ticks_driven = 0;
		rejected = 0;
		phase_flips = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, every character class, span edges, spare modes
		queue_request(make_request(MODE_TICK, $urandom, $urandom, $urandom));
		queue_request(make_request(MODE_CHAR, 0, CHAR_ZERO, $urandom));
		queue_request(make_request(MODE_CHAR, 7, CHAR_NINE, $urandom));
		queue_request(make_request(MODE_CHAR, 3, CHAR_SPACE, $urandom));
		queue_request(make_request(MODE_CHAR, 1, CHAR_ZERO - 1, $urandom));
		queue_request(make_request(MODE_CHAR, 2, CHAR_NINE + 1, $urandom));
		queue_request(make_request(MODE_CHAR, 4, 8'hff, $urandom));
		queue_request(make_request(MODE_RAW, 5, 8'hff, $urandom));
		queue_request(make_request(MODE_RAW, 6, 8'h00, $urandom));
		queue_request(make_request(MODE_DOTS, 0, $urandom, DIGITS));
		queue_request(make_request(MODE_DOTS, 5, $urandom, 4));
		queue_request(make_request(MODE_DOTS, 2, $urandom, 0));
		queue_request(make_request(MODE_DOTS, 7, $urandom, '1));
		for (m = MODE_CLEAR + 1; m <= MODE_LAST_CODE; m++)
			queue_request(make_request(m, $urandom, $urandom, $urandom));
		repeat (DIGITS) queue_request(make_request(MODE_TICK, $urandom, $urandom, $urandom));
		queue_request(make_request(MODE_CLEAR, $urandom, $urandom, $urandom));
		repeat (2) queue_request(make_request(MODE_TICK, $urandom, $urandom, $urandom));
		drain();

		// random requests under each register setting
		for (k = 0; k < SETTINGS_RUN; k++) begin
			apply_setting(k);
			n = active_digits();
			repeat (PHASE_REQUESTS) queue_request(random_request(n));
			drain();
		end

		$display("Checked %0d requests over %0d register settings", accepted_count, SETTINGS_RUN);
		$display("%0d refresh ticks, %0d rejected requests, %0d blink phase changes",
			ticks_driven, rejected, phase_flips);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$display("Timeout with %0d of %0d requests accepted", accepted_count, queued_count);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
